>>> hdl/rti_pkg.sv
package rti_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int RAW_W           = 16;
   localparam int CI              = 17;
   localparam int DW              = CI + 1;
   localparam int PW              = 2 * DW + 1;
   localparam int MW              = DW + PW;
   localparam int AW              = MW + 2;
   localparam int NW              = AW;
   localparam int FRAC_W          = 16;
   localparam int INT_W           = 17;
   localparam int QW              = INT_W + FRAC_W;
   localparam int REM_W           = NW + FRAC_W;
   localparam int DIV_W           = NW + QW - 1;
   localparam int CNT_W           = 6;
   localparam int EPS_W           = 32;
   localparam int DIST_W          = 32;
   localparam int BARY_W          = 17;
   localparam int REQ_DATA_W      = 104;
   localparam int RSP_DATA_W      = 72;
   localparam int MAC_STEPS       = 24;
   localparam int STEP_W          = 5;
   localparam int VTX_COUNT       = 3;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_W          = 1;
   localparam int QCNT_W          = 2;

   localparam logic [EPS_W-1:0]  EPS_RESET = 32'd16;
   localparam logic [DIST_W-1:0] MISS_DIST = 32'hFFFF_0000;
   localparam logic [DIST_W-1:0] DIST_MAX  = 32'h7FFF_FFFF;
   localparam logic [DIST_W-1:0] DIST_MIN  = 32'h8000_0000;
   localparam logic              CMD_VERTEX = 1'b0;
   localparam logic              CMD_RAY    = 1'b1;

   typedef struct packed {
      logic [RAW_W-1:0] x;
      logic [RAW_W-1:0] y;
      logic [RAW_W-1:0] z;
   } raw3_type;

   typedef struct packed {
      logic [DW-1:0] x;
      logic [DW-1:0] y;
      logic [DW-1:0] z;
   } vec_type;

   typedef struct packed {
      vec_type dir;
      vec_type e1;
      vec_type e2;
      vec_type tv;
   } item_type;

   typedef enum logic [1:0] {A_DIR, A_E1, A_TV, A_E2} avec_type;
   typedef enum logic [1:0] {B_E2, B_E1, B_P, B_Q} bvec_type;
   typedef enum logic [3:0] {
      D_NONE, D_P0, D_P1, D_P2, D_DET, D_UN, D_Q0, D_Q1, D_Q2, D_VN, D_TN
   } dest_type;

   typedef struct packed {
      avec_type   a_vec;
      logic [1:0] a_idx;
      bvec_type   b_vec;
      logic [1:0] b_idx;
      logic       first;
      logic       last;
      logic       sub;
      dest_type   dest;
   } step_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MAC, ST_DRAIN, ST_CHECK, ST_T_GO, ST_T_WAIT,
      ST_U_GO, ST_U_WAIT, ST_V_GO, ST_V_WAIT, ST_OUT
   } back_state_type;

   typedef struct packed {
      logic          start;
      logic [NW-1:0] num;
      logic [NW-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic          done;
      logic          ovf;
      logic [QW-1:0] quo;
   } div_rsp_type;

   function automatic step_type mk_step(avec_type av, logic [1:0] ai, bvec_type bv,
                                        logic [1:0] bi, logic first, logic last,
                                        logic sub, dest_type dest);
      step_type s;
      s.a_vec = av;
      s.a_idx = ai;
      s.b_vec = bv;
      s.b_idx = bi;
      s.first = first;
      s.last  = last;
      s.sub   = sub;
      s.dest  = dest;
      return s;
   endfunction

   function automatic step_type mac_step(logic [STEP_W-1:0] s);
      step_type r;
      case (s)
         5'd0:  r = mk_step(A_DIR, 2'd1, B_E2, 2'd2, 1'b1, 1'b0, 1'b0, D_NONE);
         5'd1:  r = mk_step(A_DIR, 2'd2, B_E2, 2'd1, 1'b0, 1'b1, 1'b1, D_P0);
         5'd2:  r = mk_step(A_DIR, 2'd2, B_E2, 2'd0, 1'b1, 1'b0, 1'b0, D_NONE);
         5'd3:  r = mk_step(A_DIR, 2'd0, B_E2, 2'd2, 1'b0, 1'b1, 1'b1, D_P1);
         5'd4:  r = mk_step(A_DIR, 2'd0, B_E2, 2'd1, 1'b1, 1'b0, 1'b0, D_NONE);
         5'd5:  r = mk_step(A_DIR, 2'd1, B_E2, 2'd0, 1'b0, 1'b1, 1'b1, D_P2);
         5'd6:  r = mk_step(A_E1,  2'd0, B_P,  2'd0, 1'b1, 1'b0, 1'b0, D_NONE);
         5'd7:  r = mk_step(A_E1,  2'd1, B_P,  2'd1, 1'b0, 1'b0, 1'b0, D_NONE);
         5'd8:  r = mk_step(A_E1,  2'd2, B_P,  2'd2, 1'b0, 1'b1, 1'b0, D_DET);
         5'd9:  r = mk_step(A_TV,  2'd0, B_P,  2'd0, 1'b1, 1'b0, 1'b0, D_NONE);
         5'd10: r = mk_step(A_TV,  2'd1, B_P,  2'd1, 1'b0, 1'b0, 1'b0, D_NONE);
         5'd11: r = mk_step(A_TV,  2'd2, B_P,  2'd2, 1'b0, 1'b1, 1'b0, D_UN);
         5'd12: r = mk_step(A_TV,  2'd1, B_E1, 2'd2, 1'b1, 1'b0, 1'b0, D_NONE);
         5'd13: r = mk_step(A_TV,  2'd2, B_E1, 2'd1, 1'b0, 1'b1, 1'b1, D_Q0);
         5'd14: r = mk_step(A_TV,  2'd2, B_E1, 2'd0, 1'b1, 1'b0, 1'b0, D_NONE);
         5'd15: r = mk_step(A_TV,  2'd0, B_E1, 2'd2, 1'b0, 1'b1, 1'b1, D_Q1);
         5'd16: r = mk_step(A_TV,  2'd0, B_E1, 2'd1, 1'b1, 1'b0, 1'b0, D_NONE);
         5'd17: r = mk_step(A_TV,  2'd1, B_E1, 2'd0, 1'b0, 1'b1, 1'b1, D_Q2);
         5'd18: r = mk_step(A_DIR, 2'd0, B_Q,  2'd0, 1'b1, 1'b0, 1'b0, D_NONE);
         5'd19: r = mk_step(A_DIR, 2'd1, B_Q,  2'd1, 1'b0, 1'b0, 1'b0, D_NONE);
         5'd20: r = mk_step(A_DIR, 2'd2, B_Q,  2'd2, 1'b0, 1'b1, 1'b0, D_VN);
         5'd21: r = mk_step(A_E2,  2'd0, B_Q,  2'd0, 1'b1, 1'b0, 1'b0, D_NONE);
         5'd22: r = mk_step(A_E2,  2'd1, B_Q,  2'd1, 1'b0, 1'b0, 1'b0, D_NONE);
         5'd23: r = mk_step(A_E2,  2'd2, B_Q,  2'd2, 1'b0, 1'b1, 1'b0, D_TN);
         default: r = mk_step(A_DIR, 2'd0, B_E2, 2'd0, 1'b1, 1'b0, 1'b0, D_NONE);
      endcase
      return r;
   endfunction

   function automatic logic [DW-1:0] pick(vec_type v, logic [1:0] i);
      logic [DW-1:0] r;
      case (i)
         2'd0:    r = v.x;
         2'd1:    r = v.y;
         default: r = v.z;
      endcase
      return r;
   endfunction

endpackage

>>> hdl/rti_front.sv
module rti_front #(
   parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [rti_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                          req_tuser,
   output logic                          push,
   output rti_pkg::item_type             push_item,
   input  logic                          full
);
   import rti_pkg::*;

   raw3_type         vtx_ff [VTX_COUNT];
   raw3_type         vtx_in;
   logic [1:0]       vidx;
   logic             vtx_we;
   logic             accept;
   raw3_type         pos;
   raw3_type         dir;
   logic [CI-1:0]    v0x, v0y, v0z;

   function automatic logic [CI-1:0] sext(logic [RAW_W-1:0] raw);
      logic [CI-1:0] r;
      logic          sgn;
      sgn = (COORD_WIDTH <= RAW_W) ? raw[(COORD_WIDTH <= RAW_W) ? COORD_WIDTH - 1 : 0] : 1'b0;
      for (int i = 0; i < RAW_W; i++) begin
         r[i] = (i < COORD_WIDTH) ? raw[i] : sgn;
      end
      r[CI-1] = sgn;
      return r;
   endfunction

   function automatic logic [DW-1:0] diff(logic [CI-1:0] a, logic [CI-1:0] b);
      return DW'($signed(a)) - DW'($signed(b));
   endfunction

   assign vidx       = req_tdata[1:0];
   assign pos.x      = req_tdata[17:2];
   assign pos.y      = req_tdata[33:18];
   assign pos.z      = req_tdata[49:34];
   assign dir.x      = req_tdata[65:50];
   assign dir.y      = req_tdata[81:66];
   assign dir.z      = req_tdata[97:82];
   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;
   assign vtx_we     = accept && (req_tuser == CMD_VERTEX) && (vidx inside {[2'd0:2'd2]});
   assign vtx_in     = pos;
   assign push       = accept && (req_tuser == CMD_RAY);

   assign v0x = sext(vtx_ff[0].x);
   assign v0y = sext(vtx_ff[0].y);
   assign v0z = sext(vtx_ff[0].z);

   always_comb begin
      push_item.dir.x = DW'($signed(sext(dir.x)));
      push_item.dir.y = DW'($signed(sext(dir.y)));
      push_item.dir.z = DW'($signed(sext(dir.z)));
      push_item.e1.x  = diff(sext(vtx_ff[1].x), v0x);
      push_item.e1.y  = diff(sext(vtx_ff[1].y), v0y);
      push_item.e1.z  = diff(sext(vtx_ff[1].z), v0z);
      push_item.e2.x  = diff(sext(vtx_ff[2].x), v0x);
      push_item.e2.y  = diff(sext(vtx_ff[2].y), v0y);
      push_item.e2.z  = diff(sext(vtx_ff[2].z), v0z);
      push_item.tv.x  = diff(sext(pos.x), v0x);
      push_item.tv.y  = diff(sext(pos.y), v0y);
      push_item.tv.z  = diff(sext(pos.z), v0z);
   end

   always_ff @(posedge clock) begin
      if (vtx_we) begin
         vtx_ff[vidx] <= vtx_in;
      end
   end

endmodule

>>> hdl/rti_queue.sv
module rti_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rti_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output rti_pkg::item_type item
);
   import rti_pkg::*;

   item_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign valid = (cnt_ff != '0);
   assign item  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

>>> hdl/rti_div.sv
module rti_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rti_pkg::div_req_type req,
   output rti_pkg::div_rsp_type rsp
);
   import rti_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [QW-1:0]    quo_ff, quo_in;
   logic             ge;

   assign ge = DIV_W'(rem_ff) >= dvs_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = '0;
         rem_in  = {req.num, FRAC_W'(0)};
         dvs_in  = {req.den, (QW - 1)'(0)};
         ovf_in  = (NW + INT_W)'(req.num) >= {req.den, INT_W'(0)};
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - dvs_ff[REM_W-1:0];
         end
         quo_in = {quo_ff[QW-2:0], ge};
         dvs_in = dvs_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      ovf_ff <= ovf_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign rsp.done = done_ff;
   assign rsp.ovf  = ovf_ff;
   assign rsp.quo  = quo_ff;

endmodule

>>> hdl/rti_back.sv
module rti_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   input  rti_pkg::item_type              q_item,
   output logic                           q_pop,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rti_pkg::EPS_W-1:0]      csr_data,
   output rti_pkg::div_req_type           div_req,
   input  rti_pkg::div_rsp_type           div_rsp,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rti_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tuser
);
   import rti_pkg::*;

   back_state_type          state_ff, state_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   item_type                item_ff, item_in;
   logic signed [MW-1:0]    prod_ff, prod_in;
   step_type                ctl_ff, ctl_in;
   logic                    pv_ff, pv_in;
   logic signed [AW-1:0]    acc_ff, acc_in;
   logic signed [PW-1:0]    p0_ff, p1_ff, p2_ff, q0_ff, q1_ff, q2_ff;
   logic signed [PW-1:0]    p0_in, p1_in, p2_in, q0_in, q1_in, q2_in;
   logic signed [AW-1:0]    det_ff, un_ff, vn_ff, tn_ff;
   logic signed [AW-1:0]    det_in, un_in, vn_in, tn_in;
   logic [NW-1:0]           adet_ff, un_m_ff, vn_m_ff, tn_m_ff;
   logic [NW-1:0]           adet_in, un_m_in, vn_m_in, tn_m_in;
   logic                    tneg_ff, tneg_in;
   logic                    hit_ff, hit_in;
   logic [DIST_W-1:0]       dist_ff, dist_in;
   logic [BARY_W-1:0]       u_ff, u_in, v_ff, v_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic [EPS_W-1:0]        eps_ff, eps_in;

   step_type                cur;
   logic signed [DW-1:0]    a_op;
   logic signed [PW-1:0]    b_op;
   logic signed [AW-1:0]    prod_ext, sum;
   logic                    dneg;
   logic [AW-1:0]           adet, un_a, vn_a, tn_a;
   logic                    miss;
   logic                    big;

   function automatic logic [PW-1:0] pick3(logic [PW-1:0] a, logic [PW-1:0] b,
                                           logic [PW-1:0] c, logic [1:0] i);
      logic [PW-1:0] r;
      case (i)
         2'd0:    r = a;
         2'd1:    r = b;
         default: r = c;
      endcase
      return r;
   endfunction

   assign cur = mac_step(step_ff);

   always_comb begin
      case (cur.a_vec)
         A_DIR:   a_op = $signed(pick(item_ff.dir, cur.a_idx));
         A_E1:    a_op = $signed(pick(item_ff.e1, cur.a_idx));
         A_TV:    a_op = $signed(pick(item_ff.tv, cur.a_idx));
         default: a_op = $signed(pick(item_ff.e2, cur.a_idx));
      endcase
      case (cur.b_vec)
         B_E2:    b_op = PW'($signed(pick(item_ff.e2, cur.b_idx)));
         B_E1:    b_op = PW'($signed(pick(item_ff.e1, cur.b_idx)));
         B_P:     b_op = $signed(pick3(p0_ff, p1_ff, p2_ff, cur.b_idx));
         default: b_op = $signed(pick3(q0_ff, q1_ff, q2_ff, cur.b_idx));
      endcase
   end

   assign prod_in  = a_op * b_op;
   assign prod_ext = AW'(prod_ff);
   assign sum      = (ctl_ff.first ? AW'(0) : acc_ff) + (ctl_ff.sub ? -prod_ext : prod_ext);

   assign dneg = det_ff[AW-1];
   assign adet = dneg ? AW'(-det_ff) : AW'(det_ff);
   assign un_a = dneg ? AW'(-un_ff) : AW'(un_ff);
   assign vn_a = dneg ? AW'(-vn_ff) : AW'(vn_ff);
   assign tn_a = dneg ? AW'(-tn_ff) : AW'(tn_ff);
   assign miss = (det_ff == '0) || (adet < AW'(eps_ff)) || un_a[AW-1] || (un_a > adet)
                 || vn_a[AW-1] || ((AW + 1)'(un_a) + (AW + 1)'(vn_a) > (AW + 1)'(adet));

   always_comb begin
      if (tneg_ff) begin
         big = div_rsp.ovf || div_rsp.quo[QW-1]
               || (div_rsp.quo[DIST_W-1] && (div_rsp.quo[DIST_W-2:0] != '0));
      end else begin
         big = div_rsp.ovf || (div_rsp.quo[QW-1:DIST_W-1] != '0);
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      item_in      = item_ff;
      ctl_in       = cur;
      pv_in        = 1'b0;
      acc_in       = acc_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      q0_in        = q0_ff;
      q1_in        = q1_ff;
      q2_in        = q2_ff;
      det_in       = det_ff;
      un_in        = un_ff;
      vn_in        = vn_ff;
      tn_in        = tn_ff;
      adet_in      = adet_ff;
      un_m_in      = un_m_ff;
      vn_m_in      = vn_m_ff;
      tn_m_in      = tn_m_ff;
      tneg_in      = tneg_ff;
      hit_in       = hit_ff;
      dist_in      = dist_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_hit_in   = rsp_hit_ff;
      eps_in       = csr_valid ? csr_data : eps_ff;
      q_pop        = 1'b0;
      div_req.start = 1'b0;
      div_req.den   = adet_ff;
      case (state_ff)
         ST_T_GO: div_req.num = tn_m_ff;
         ST_U_GO: div_req.num = un_m_ff;
         default: div_req.num = vn_m_ff;
      endcase

      if (pv_ff) begin
         acc_in = sum;
         if (ctl_ff.last) begin
            case (ctl_ff.dest)
               D_P0:    p0_in = sum[PW-1:0];
               D_P1:    p1_in = sum[PW-1:0];
               D_P2:    p2_in = sum[PW-1:0];
               D_Q0:    q0_in = sum[PW-1:0];
               D_Q1:    q1_in = sum[PW-1:0];
               D_Q2:    q2_in = sum[PW-1:0];
               D_DET:   det_in = sum;
               D_UN:    un_in = sum;
               D_VN:    vn_in = sum;
               D_TN:    tn_in = sum;
               default: ;
            endcase
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               step_in  = '0;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            pv_in   = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(MAC_STEPS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            adet_in = adet;
            un_m_in = un_a;
            vn_m_in = vn_a;
            tneg_in = tn_a[AW-1];
            tn_m_in = tn_a[AW-1] ? -tn_a : tn_a;
            if (miss) begin
               hit_in   = 1'b0;
               dist_in  = MISS_DIST;
               u_in     = '0;
               v_in     = '0;
               state_in = ST_OUT;
            end else begin
               state_in = ST_T_GO;
            end
         end
         ST_T_GO: begin
            div_req.start = 1'b1;
            state_in      = ST_T_WAIT;
         end
         ST_T_WAIT: begin
            if (div_rsp.done) begin
               if (tneg_ff) begin
                  dist_in = big ? DIST_MIN : -div_rsp.quo[DIST_W-1:0];
               end else begin
                  dist_in = big ? DIST_MAX : div_rsp.quo[DIST_W-1:0];
               end
               state_in = ST_U_GO;
            end
         end
         ST_U_GO: begin
            div_req.start = 1'b1;
            state_in      = ST_U_WAIT;
         end
         ST_U_WAIT: begin
            if (div_rsp.done) begin
               u_in     = div_rsp.quo[BARY_W-1:0];
               state_in = ST_V_GO;
            end
         end
         ST_V_GO: begin
            div_req.start = 1'b1;
            state_in      = ST_V_WAIT;
         end
         ST_V_WAIT: begin
            if (div_rsp.done) begin
               v_in     = div_rsp.quo[BARY_W-1:0];
               hit_in   = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'b0, v_ff, u_ff, dist_ff};
               rsp_hit_in   = hit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         eps_ff       <= EPS_RESET;
      end else begin
         state_ff     <= state_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
         eps_ff       <= eps_in;
      end
      step_ff     <= step_in;
      item_ff     <= item_in;
      prod_ff     <= prod_in;
      ctl_ff      <= ctl_in;
      acc_ff      <= acc_in;
      p0_ff       <= p0_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      q0_ff       <= q0_in;
      q1_ff       <= q1_in;
      q2_ff       <= q2_in;
      det_ff      <= det_in;
      un_ff       <= un_in;
      vn_ff       <= vn_in;
      tn_ff       <= tn_in;
      adet_ff     <= adet_in;
      un_m_ff     <= un_m_in;
      vn_m_ff     <= vn_m_in;
      tn_m_ff     <= tn_m_in;
      tneg_ff     <= tneg_in;
      hit_ff      <= hit_in;
      dist_ff     <= dist_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      rsp_data_ff <= rsp_data_in;
      rsp_hit_ff  <= rsp_hit_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_hit_ff;

endmodule

>>> hdl/ray_triangle_intersect.sv
// Fixed-point Moller-Trumbore ray/triangle test. A request with tuser low writes one vertex
// of the stored triangle and gives no response; a request with tuser high tests a ray and
// gives exactly one response. The front end takes requests into a two-entry queue while
// the back end works: one shared 18 by 37 bit multiplier forms the 24 products of the
// determinant and the u, v and t numerators, and one bit-serial divider then forms t, u
// and v in turn. All three vertices must be written before the first ray.
module ray_triangle_intersect #(
   parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // vertex_index, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, zero fill
   input  logic [rti_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // distance, bary_u, bary_v, zero fill
   output logic [rti_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // hit
   output logic                           rsp_tuser,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rti_pkg::EPS_W-1:0]      csr_data
);
   import rti_pkg::*;

   logic        push;
   item_type    push_item;
   logic        full;
   logic        pop;
   logic        q_valid;
   item_type    q_item;
   div_req_type div_req;
   div_rsp_type div_rsp;

   rti_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock      (clock),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push       (push),
      .push_item  (push_item),
      .full       (full)
   );

   rti_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .valid     (q_valid),
      .item      (q_item)
   );

   rti_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   rti_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (pop),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
